FILE: design/distributed_arithmetic_fir_unit_macros.svh
// Assertion macros for the DA FIR unit.
`ifndef DISTRIBUTED_ARITHMETIC_FIR_UNIT_MACROS_SVH
`define DISTRIBUTED_ARITHMETIC_FIR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define DAF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define DAF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DAF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg)
`define DAF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

FILE: design/daf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package daf_pkg;

    localparam int TAPS_DEF        = 4;
    localparam int INPUT_WIDTH_DEF = 12;
    localparam int COEF_WIDTH_DEF  = 16;

    localparam int NUM_COEF_REGS = 4;
    localparam int OUT_W         = 30;
    localparam int CFG_IDX_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 3'd4;

    typedef enum logic [2:0] {
        ST_BUILD,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FIN
    } t_daf_state;

    typedef struct packed {
        logic build_clear;
        logic build_we;
        logic accept;
        logic rd_plane;
        logic load_out;
    } t_daf_cmd;

    typedef struct packed {
        logic coef_write;
        logic build_last;
        logic plane_zero;
        logic out_free;
    } t_daf_status;

endpackage

`default_nettype wire

FILE: design/daf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module daf_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  daf_pkg::t_daf_status  i_status,
    output daf_pkg::t_daf_cmd     o_cmd
);
    import daf_pkg::*;

    t_daf_state r_state;
    t_daf_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_BUILD;
        end else begin
            r_state <= n_state;
        end
    end

    // a coefficient write holds the input off so no word slips past the rebuild
    assign o_in_stall = (r_state != ST_IDLE) || i_status.coef_write;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_BUILD: begin
                if (!i_status.coef_write) begin
                    o_cmd.build_we = 1'b1;
                    if (i_status.build_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.rd_plane = 1'b1;
                if (i_status.plane_zero) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last table word is being accumulated
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_BUILD;
            end
        endcase
        // a coefficient change restarts the table sweep
        if (i_status.coef_write) begin
            o_cmd.build_clear = 1'b1;
            o_cmd.build_we    = 1'b0;
            o_cmd.accept      = 1'b0;
            n_state           = ST_BUILD;
        end
    end

endmodule

`default_nettype wire

FILE: design/daf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module daf_datapath #(
    parameter int TAPS        = daf_pkg::TAPS_DEF,
    parameter int INPUT_WIDTH = daf_pkg::INPUT_WIDTH_DEF,
    parameter int COEF_WIDTH  = daf_pkg::COEF_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [daf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [COEF_WIDTH-1:0]             i_cfg_data,
    input  logic [INPUT_WIDTH-1:0]            i_sample_bits,
    input  logic                              i_start_block,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic signed [daf_pkg::OUT_W-1:0]  o_filtered,
    input  daf_pkg::t_daf_cmd                 i_cmd,
    output daf_pkg::t_daf_status              o_status
);
    import daf_pkg::*;

    localparam int NUM_COEF    = (TAPS < NUM_COEF_REGS) ? TAPS : NUM_COEF_REGS;
    localparam int ENTRY_W     = COEF_WIDTH + 2;
    localparam int TABLE_DEPTH = 1 << TAPS;
    localparam int PLANE_W     = $clog2(INPUT_WIDTH);

    logic signed [COEF_WIDTH-1:0]  r_coef [NUM_COEF];
    logic                          r_signed_mode;
    logic [INPUT_WIDTH-1:0]        r_hist [TAPS];
    logic [ENTRY_W-1:0]            r_table [TABLE_DEPTH];
    logic [TAPS-1:0]               r_build_addr;
    logic [PLANE_W-1:0]            r_plane;
    logic [ENTRY_W-1:0]            r_rd_data;
    logic                          r_rd_valid;
    logic                          r_rd_top;
    logic [OUT_W-1:0]              r_acc;
    logic [OUT_W-1:0]              n_acc;
    logic signed [OUT_W-1:0]       r_out;
    logic                          r_out_valid;

    logic [ENTRY_W-1:0]            build_sum;
    logic [TAPS-1:0]               rd_addr;
    logic [OUT_W-1:0]              term_ext;
    logic [OUT_W-1:0]              term;
    logic                          coef_write;

    // config registers
    assign coef_write = i_cfg_we && (i_cfg_index < CFG_IDX_W'(NUM_COEF));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < NUM_COEF; t++) begin
                r_coef[t] <= '0;
            end
            r_signed_mode <= 1'b1;
        end else if (i_cfg_we) begin
            for (int t = 0; t < NUM_COEF; t++) begin
                if (i_cfg_index == REG_COEF_0 + CFG_IDX_W'(t)) begin
                    r_coef[t] <= i_cfg_data;
                end
            end
            if (i_cfg_index == REG_SIGNED_MODE) begin
                r_signed_mode <= i_cfg_data[0];
            end
        end
    end

    // partial-sum table, rebuilt one entry per cycle unless a coefficient write restarts it
    always_comb begin
        build_sum = '0;
        for (int t = 0; t < NUM_COEF; t++) begin
            if (r_build_addr[t]) begin
                build_sum = build_sum
                          + {{(ENTRY_W-COEF_WIDTH){r_coef[t][COEF_WIDTH-1]}}, r_coef[t]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_build_addr <= '0;
        end else if (i_cmd.build_clear) begin
            r_build_addr <= '0;
        end else if (i_cmd.build_we) begin
            r_build_addr <= r_build_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.build_we) begin
            r_table[r_build_addr] <= build_sum;
        end
    end

    // delay line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TAPS; t++) begin
                r_hist[t] <= '0;
            end
        end else if (i_cmd.accept) begin
            r_hist[0] <= i_sample_bits;
            for (int t = 1; t < TAPS; t++) begin
                r_hist[t] <= i_start_block ? '0 : r_hist[t-1];
            end
        end
    end

    // bit-plane address, MSB plane first
    always_comb begin
        for (int t = 0; t < TAPS; t++) begin
            rd_addr[t] = r_hist[t][r_plane];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_cmd.accept) begin
            r_plane <= PLANE_W'(INPUT_WIDTH - 1);
        end else if (i_cmd.rd_plane) begin
            r_plane <= r_plane - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_plane) begin
            r_rd_data <= r_table[rd_addr];
            r_rd_top  <= (r_plane == PLANE_W'(INPUT_WIDTH - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.rd_plane;
        end
    end

    // Horner accumulation: acc = 2*acc +/- entry; sign plane subtracts in signed mode
    assign term_ext = {{(OUT_W-ENTRY_W){r_rd_data[ENTRY_W-1]}}, r_rd_data};
    assign term     = (r_rd_top && r_signed_mode) ? (~term_ext + 1'b1) : term_ext;
    assign n_acc    = {r_acc[OUT_W-2:0], 1'b0} + term;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_acc <= '0;
        end else if (r_rd_valid) begin
            r_acc <= n_acc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= r_acc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_out;

    assign o_status.coef_write = coef_write;
    assign o_status.build_last = &r_build_addr;
    assign o_status.plane_zero = (r_plane == '0);
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

endmodule

`default_nettype wire

FILE: design/distributed_arithmetic_fir_unit.sv
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid / o_in_stall  i_sample_bits, i_start_block
// out       output     o_out_valid / i_out_stall o_filtered
// cfg       input      i_cfg_we                i_cfg_index, i_cfg_data
//
// Each input word goes through these steps: one to take it, one table read per
// bit plane from the single-port partial-sum memory, one to add the last plane,
// one to load the result register.
// After reset and after each coefficient write all 2^TAPS table entries are rebuilt, one per
// cycle unless a further coefficient write restarts the sweep, with the input stalled.
// The result register lets a new word in while the last result waits; the block
// holds its next result until that register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "distributed_arithmetic_fir_unit_macros.svh"

module distributed_arithmetic_fir_unit #(
    parameter int TAPS        = daf_pkg::TAPS_DEF,
    parameter int INPUT_WIDTH = daf_pkg::INPUT_WIDTH_DEF,
    parameter int COEF_WIDTH  = daf_pkg::COEF_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [daf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [COEF_WIDTH-1:0]             i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [INPUT_WIDTH-1:0]            i_sample_bits,
    input  logic                              i_start_block,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [daf_pkg::OUT_W-1:0]  o_filtered
);
    import daf_pkg::*;

    t_daf_cmd    cmd;
    t_daf_status status;

    daf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    daf_datapath #(
        .TAPS        (TAPS),
        .INPUT_WIDTH (INPUT_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_sample_bits (i_sample_bits),
        .i_start_block (i_start_block),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_filtered    (o_filtered),
        .i_cmd         (cmd),
        .o_status      (status)
    );

    `DAF_ASSERT_NEXT(a_accept_then_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken while previous word still in work")
    `DAF_ASSERT_NEXT(a_coef_rebuild, i_clk, i_rst_n, status.coef_write, o_in_stall, "input open during table rebuild")
    `DAF_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, cmd.load_out, status.out_free, "result register overwritten")
    `DAF_ASSERT_NOW(a_build_excl, i_clk, i_rst_n, cmd.build_we, !cmd.rd_plane && !cmd.accept, "table write during filtering")

endmodule

`default_nettype wire
